// ===== rtl/core/skvt_pkg.sv =====
// Shared sizes, action codes and inter-module structs of the sparse key/value table.
// No dependencies.
`default_nettype none

package skvt_pkg;

    // Table size and derived widths
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int OUT_CNT_W = 7;

    // Action codes of an input word
    typedef enum logic [1:0] {
        ACT_SET   = 2'd0,
        ACT_UNSET = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    // Result of the parallel key compare and free-slot search
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free_any;
        logic [IDX_W-1:0] free_idx;
    } skvt_lookup_t;

    // Slot changes requested by the top level
    typedef struct packed {
        logic insert;   // claim lowest free slot for the key
        logic remove;   // drop the slot that holds the key
    } skvt_update_t;

    // One-hot (or zero) vector to slot index
    function automatic logic [IDX_W-1:0] onehot_to_idx(input logic [CAPACITY-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (vec[i])
            begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sparse_key_value_table.sv =====
// Top level of the sparse key/value table: input register, value memory, result register.
// Depends on skvt_pkg and skvt_match.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word: action, index, value.
//   action 0 sets index to value, 1 removes index, 2 queries index, 3 does nothing.
//   Output channel (out_valid / out_stall) returns one word per input word:
//   found, read_value, entry_count, rejected_full.
//   A word is taken into the input register at an edge with valid high and stall low;
//   from there, unless out_stall holds the result, its key is compared against all
//   slots, the table is updated and the result register is loaded, raising out_valid.
//   Throughput is one word per cycle while out_stall does not hold the result: the key
//   compare, free-slot search and one write/read of the value memory all settle in the
//   same cycle, and the table state is updated before the following word is looked up.
//   When out_stall holds the result, the word in the input register waits and
//   in_stall rises; one more word can be taken while the result is pending.
//   Reset clears all valid bits and the count; the table is usable right after
//   reset with no clearing pass. A set of a new key into a full table is refused
//   with rejected_full.
`default_nettype none

module sparse_key_value_table
    import skvt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [1:0]              action,
    input  wire logic signed [KEY_W-1:0] index,
    input  wire logic signed [VAL_W-1:0] value,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         found,
    output logic signed [VAL_W-1:0]      read_value,
    output logic [OUT_CNT_W-1:0]         entry_count,
    output logic                         rejected_full
);

    // Input register
    logic             a_valid_reg;
    logic [1:0]       a_action_reg;
    logic [KEY_W-1:0] a_key_reg;
    logic [VAL_W-1:0] a_value_reg;

    // Table count and result register
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             found_reg;
    logic             query_hit_reg;
    logic             rej_reg;
    logic [VAL_W-1:0] rd_data_reg;

    logic [VAL_W-1:0] value_mem [CAPACITY];

    skvt_lookup_t     lookup;
    skvt_update_t     update;
    logic             advance;
    logic             in_take;
    logic             found_next;
    logic             query_hit_next;
    logic             rej_next;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic             table_full;

    // Handshake
    assign advance  = a_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = a_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    skvt_match u_match (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    (a_key_reg),
        .update (update),
        .lookup (lookup)
    );

    assign table_full = (count_reg >= CNT_W'(CAPACITY)) || !lookup.free_any;

    // Decode the action against the lookup
    always_comb
    begin
        update         = '0;
        found_next     = 1'b0;
        query_hit_next = 1'b0;
        rej_next       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = lookup.hit_idx;
        count_next     = count_reg;
        unique case (a_action_reg)
            ACT_SET:
            begin
                if (lookup.hit)
                begin
                    found_next = 1'b1;
                    mem_we     = 1'b1;
                end
                else if (table_full)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    update.insert = 1'b1;
                    mem_we        = 1'b1;
                    mem_waddr     = lookup.free_idx;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            ACT_UNSET:
            begin
                if (lookup.hit)
                begin
                    found_next    = 1'b1;
                    update.remove = 1'b1;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            ACT_QUERY:
            begin
                found_next     = lookup.hit;
                query_hit_next = lookup.hit;
            end
            default:
            begin
                // unused code: no change
            end
        endcase
        if (!advance)
        begin
            update     = '0;
            mem_we     = 1'b0;
            count_next = count_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                a_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            count_reg <= count_next;
        end
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_action_reg <= action;
            a_key_reg    <= index;
            a_value_reg  <= value;
        end
    end

    // Result flags
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            found_reg     <= found_next;
            query_hit_reg <= query_hit_next;
            rej_reg       <= rej_next;
        end
    end

    // Value memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            value_mem[mem_waddr] <= a_value_reg;
        end
        if (advance)
        begin
            rd_data_reg <= value_mem[lookup.hit_idx];
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign read_value    = query_hit_reg ? rd_data_reg : '0;
    assign entry_count   = OUT_CNT_W'(count_reg);
    assign rejected_full = rej_reg;

endmodule

`default_nettype wire

// ===== rtl/core/skvt_match.sv =====
// Key store of the table: valid bits and keys in flops, a compare on every slot
// and a lowest-free-slot search. Depends on skvt_pkg.
`default_nettype none

module skvt_match
    import skvt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [KEY_W-1:0] key,
    input  wire skvt_update_t     update,
    output skvt_lookup_t          lookup
);

    logic [CAPACITY-1:0] valid_reg;
    logic [CAPACITY-1:0] valid_next;
    logic [KEY_W-1:0]    key_reg [CAPACITY];

    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] free_vec;
    logic [CAPACITY-1:0] free_first;

    // Compare the key against every slot
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++) begin
            match_vec[i] = valid_reg[i] && (key_reg[i] == key);
        end
    end

    // Lowest free slot: isolate the lowest set bit of the free vector
    assign free_vec   = ~valid_reg;
    assign free_first = free_vec & (~free_vec + CAPACITY'(1));

    assign lookup.hit      = |match_vec;
    assign lookup.hit_idx  = onehot_to_idx(match_vec);
    assign lookup.free_any = |free_vec;
    assign lookup.free_idx = onehot_to_idx(free_first);

    // Valid bits after an insert or a remove
    always_comb
    begin
        valid_next = valid_reg;
        if (update.insert)
        begin
            valid_next = valid_next | free_first;
        end
        if (update.remove)
        begin
            valid_next = valid_next & ~match_vec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Keys land in the slot claimed by an insert
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (update.insert && free_first[i])
            begin
                key_reg[i] <= key;
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/skvt_checker.sv =====
// Reply checker for the sparse key/value table: keeps its own copy of the table,
// predicts the reply to every accepted word and compares replies in order.
// Depends on skvt_pkg.
`default_nettype none

module skvt_checker
    import skvt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic                    in_stall,
    input  wire logic [1:0]              action,
    input  wire logic signed [KEY_W-1:0] index,
    input  wire logic signed [VAL_W-1:0] value,
    input  wire logic                    out_valid,
    input  wire logic                    out_stall,
    input  wire logic                    found,
    input  wire logic signed [VAL_W-1:0] read_value,
    input  wire logic [OUT_CNT_W-1:0]    entry_count,
    input  wire logic                    rejected_full,
    output int                           mismatch_count,
    output int                           replies_pending
);

    typedef struct {
        logic                 found;
        logic [VAL_W-1:0]     read_value;
        logic [OUT_CNT_W-1:0] entry_count;
        logic                 rejected_full;
    } table_reply_t;

    // Shadow table
    logic             shadow_used  [CAPACITY];
    logic [KEY_W-1:0] shadow_key   [CAPACITY];
    logic [VAL_W-1:0] shadow_value [CAPACITY];
    int               shadow_count;

    table_reply_t reply_q [$];
    int           mismatch_total = 0;

    // Apply one word to the shadow table and return the reply it must produce
    function automatic table_reply_t apply_action(input logic [1:0]       act,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [VAL_W-1:0] val);
        table_reply_t r;
        int           hit;
        int           free_idx;
        int           i;
        r.found         = 1'b0;
        r.read_value    = '0;
        r.rejected_full = 1'b0;
        hit      = -1;
        free_idx = -1;
        // downward scan leaves the lowest free slot
        for (i = CAPACITY - 1; i >= 0; i--)
        begin
            if (shadow_used[i] && shadow_key[i] == key)
            begin
                hit = i;
            end
            if (!shadow_used[i])
            begin
                free_idx = i;
            end
        end
        case (act)
            ACT_SET:
            begin
                if (hit >= 0)
                begin
                    r.found           = 1'b1;
                    shadow_value[hit] = val;
                end
                else if (shadow_count >= CAPACITY || free_idx < 0)
                begin
                    r.rejected_full = 1'b1;
                end
                else
                begin
                    shadow_used[free_idx]  = 1'b1;
                    shadow_key[free_idx]   = key;
                    shadow_value[free_idx] = val;
                    shadow_count++;
                end
            end
            ACT_UNSET:
            begin
                if (hit >= 0)
                begin
                    r.found          = 1'b1;
                    shadow_used[hit] = 1'b0;
                    shadow_count--;
                end
            end
            ACT_QUERY:
            begin
                if (hit >= 0)
                begin
                    r.found      = 1'b1;
                    r.read_value = shadow_value[hit];
                end
            end
            default:
            begin
                // unused code: no change
            end
        endcase
        r.entry_count = OUT_CNT_W'(shadow_count);
        return r;
    endfunction

    function automatic void check_field(input string            name,
                                        input logic [VAL_W-1:0] want_v,
                                        input logic [VAL_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %h, got %h", name, want_v, got_v);
            mismatch_total++;
        end
    endfunction

    // Compare the reply first, then predict the word taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin : monitor
        table_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                shadow_used[i] = 1'b0;
            end
            shadow_count = 0;
            reply_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("reply word with no input word outstanding");
                    mismatch_total++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    check_field("found", VAL_W'(want.found), VAL_W'(found));
                    check_field("read_value", want.read_value, read_value);
                    check_field("entry_count", VAL_W'(want.entry_count), VAL_W'(entry_count));
                    check_field("rejected_full", VAL_W'(want.rejected_full),
                                VAL_W'(rejected_full));
                end
            end
            if (in_valid && !in_stall)
            begin
                reply_q.push_back(apply_action(action, index, value));
            end
        end
        mismatch_count  <= mismatch_total;
        replies_pending <= reply_q.size();
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench top for the sparse key/value table: clock, reset, word stimulus,
// back-pressure, watchdog and verdict. Depends on skvt_pkg, skvt_checker and the RTL.
`default_nettype none

module tb
    import skvt_pkg::*;
();

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         POOL_SIZE      = 80;
    localparam logic [1:0] ACT_NOP        = 2'd3;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    in_valid      = 1'b0;
    logic                    in_stall;
    logic [1:0]              action        = ACT_SET;
    logic signed [KEY_W-1:0] index         = '0;
    logic signed [VAL_W-1:0] value         = '0;
    logic                    out_valid;
    logic                    out_stall     = 1'b0;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic [OUT_CNT_W-1:0]    entry_count;
    logic                    rejected_full;
    int                      mismatch_count;
    int                      replies_pending;

    int               idle_pct     = 0;
    int               stall_pct    = 0;
    int               quiet_cycles = 0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sparse_key_value_table u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .index         (index),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .read_value    (read_value),
        .entry_count   (entry_count),
        .rejected_full (rejected_full)
    );

    skvt_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .index           (index),
        .value           (value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .found           (found),
        .read_value      (read_value),
        .entry_count     (entry_count),
        .rejected_full   (rejected_full),
        .mismatch_count  (mismatch_count),
        .replies_pending (replies_pending)
    );

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: too long with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drive one word, with random idle cycles ahead of it, and wait until it is taken
    task automatic send_word(input logic [1:0] act, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        index    <= key;
        value    <= val;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // Hold off the sender until every reply is back
    task automatic wait_replies();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (replies_pending != 0);
    endtask

    // Random word; weights in percent, remainder is the unused code
    task automatic send_random(input int set_w, input int unset_w, input int query_w);
        logic [1:0]       act;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        int               r;
        r = $urandom_range(99);
        if (r < set_w)
            act = ACT_SET;
        else if (r < set_w + unset_w)
            act = ACT_UNSET;
        else if (r < set_w + unset_w + query_w)
            act = ACT_QUERY;
        else
            act = ACT_NOP;
        // fresh random keys are rare on sets so they do not clog the table
        if ($urandom_range(99) < ((act == ACT_SET) ? 2 : 12))
            key = $urandom;
        else
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
        case ($urandom_range(15))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = 32'h0000_0000;
            3:       val = 32'hFFFF_FFFF;
            default: val = $urandom;
        endcase
        send_word(act, key, val);
    endtask

    initial
    begin
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            key_pool[i] = $urandom;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, extreme keys and values, overwrite, removal, unused code
        send_word(ACT_QUERY, 32'h0000_0000, 32'h0000_0000);
        send_word(ACT_UNSET, 32'h8000_0000, 32'h0000_0000);
        send_word(ACT_NOP,   32'h0000_0000, 32'hFFFF_FFFF);
        send_word(ACT_SET,   32'h8000_0000, 32'h7FFF_FFFF);
        send_word(ACT_SET,   32'h7FFF_FFFF, 32'h8000_0000);
        send_word(ACT_SET,   32'h0000_0000, 32'h0000_0000);
        send_word(ACT_SET,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(ACT_QUERY, 32'h8000_0000, 32'h0000_0000);
        send_word(ACT_QUERY, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(ACT_QUERY, 32'h0000_0000, 32'h1234_5678);
        send_word(ACT_QUERY, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(ACT_SET,   32'h8000_0000, 32'hAAAA_5555);
        send_word(ACT_QUERY, 32'h8000_0000, 32'h0000_0000);
        send_word(ACT_NOP,   32'h8000_0000, 32'h1234_5678);
        send_word(ACT_UNSET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(ACT_QUERY, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(ACT_UNSET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(ACT_SET,   32'h0000_0001, 32'h0000_0001);
        send_word(ACT_UNSET, 32'h8000_0000, 32'h0000_0000);
        send_word(ACT_UNSET, 32'h0000_0000, 32'h0000_0000);
        send_word(ACT_UNSET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(ACT_UNSET, 32'h0000_0001, 32'h0000_0000);
        send_word(ACT_QUERY, 32'hFFFF_FFFF, 32'h0000_0000);
        wait_replies();

        // Random: fill to full, churn, then drain, under each idling mix
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 50;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 50;
                end
                default:
                begin
                    idle_pct = 36;
                    stall_pct <= 36;
                end
            endcase
            repeat (200) send_random(80, 5, 10);
            repeat (130) send_random(35, 25, 35);
            repeat (100) send_random(10, 65, 20);
            wait_replies();
        end

        stall_pct <= 0;
        wait_replies();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && replies_pending == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/skvt_pkg.sv
rtl/core/skvt_match.sv
rtl/core/sparse_key_value_table.sv
tb/skvt_checker.sv
tb/tb.sv
